[hdl/fltpw_pkg.sv]
// Shared types, constants and helpers for the four-level page table walker.
package fltpw_pkg;

  localparam int FrameBits  = 40;
  localparam int PageShift  = 12;
  localparam int VaW        = 48;
  localparam int AddrW      = 52;
  localparam int EntryW     = 64;
  localparam int IdxW       = 9;
  localparam int LevelW     = 2;
  localparam int QDepth     = 2;
  localparam int QPtrW      = $clog2(QDepth);
  localparam int QCntW      = $clog2(QDepth + 1);
  localparam logic [LevelW-1:0] LastLevel = LevelW'(3);

  typedef enum logic [1:0] {
    KindRead  = 2'd0,
    KindDone  = 2'd1,
    KindFault = 2'd2,
    KindProto = 2'd3
  } kind_e;

  // one classified walk step, handed from front to back
  typedef struct packed {
    kind_e                 kind;
    logic [FrameBits-1:0]  frame;
    logic [IdxW-1:0]       idx;
    logic [LevelW-1:0]     level;
    logic [EntryW-1:0]     entry;
  } step_t;

  function automatic logic [IdxW-1:0] level_index(input logic [VaW-1:0] va,
                                                  input logic [LevelW-1:0] lvl);
    logic [IdxW-1:0] r;
    unique case (lvl)
      2'd0:    r = va[39 +: IdxW];
      2'd1:    r = va[30 +: IdxW];
      2'd2:    r = va[21 +: IdxW];
      default: r = va[12 +: IdxW];
    endcase
    return r;
  endfunction

endpackage

[hdl/fltpw_front.sv]
// Front end: accepts items, tracks the walk state and classifies each step.
module fltpw_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  logic                            full_i,
  input  logic                            req_type_i,
  input  logic [fltpw_pkg::VaW-1:0]       virtual_address_i,
  input  logic [fltpw_pkg::FrameBits-1:0] root_frame_i,
  input  logic [fltpw_pkg::EntryW-1:0]    entry_data_i,
  output logic                            wr_o,
  output fltpw_pkg::step_t                wr_data_o
);
  import fltpw_pkg::*;

  logic              busy_q, busy_d;
  logic [LevelW-1:0] level_q, level_d;
  logic [VaW-1:0]    held_q, held_d;
  logic              acc;
  step_t             step;

  assign acc       = push_i && !full_i;
  assign wr_o      = acc;
  assign wr_data_o = step;

  always_comb begin
    busy_d     = busy_q;
    level_d    = level_q;
    held_d     = held_q;
    step.kind  = KindProto;
    step.frame = '0;
    step.idx   = '0;
    step.level = '0;
    step.entry = '0;
    if (!req_type_i) begin
      if (!busy_q) begin
        busy_d     = 1'b1;
        level_d    = '0;
        held_d     = virtual_address_i;
        step.kind  = KindRead;
        step.frame = root_frame_i;
        step.idx   = level_index(virtual_address_i, '0);
      end
    end else if (busy_q) begin
      step.level = level_q;
      step.entry = entry_data_i;
      step.frame = entry_data_i[PageShift +: FrameBits];
      priority if (!entry_data_i[0]) begin
        step.kind = KindFault;
        busy_d    = 1'b0;
        level_d   = '0;
      end else if (level_q == LastLevel) begin
        step.kind = KindDone;
        busy_d    = 1'b0;
        level_d   = '0;
      end else begin
        step.kind = KindRead;
        step.idx  = level_index(held_q, level_q + LevelW'(1));
        level_d   = level_q + LevelW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      level_q <= '0;
      held_q  <= '0;
    end else if (acc) begin
      busy_q  <= busy_d;
      level_q <= level_d;
      held_q  <= held_d;
    end
  end

  a_idle_level_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> level_q == '0)
    else $error("level nonzero while idle");

  a_stray_resp_keeps_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && req_type_i && !busy_q |=> !busy_q && $stable(held_q))
    else $error("response while idle changed state");

  a_req_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !req_type_i && busy_q |=> busy_q && $stable(level_q) && $stable(held_q))
    else $error("request while busy disturbed the walk");

endmodule

[hdl/fltpw_queue.sv]
// Short queue of classified steps between front and back.
module fltpw_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  fltpw_pkg::step_t wr_data_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic             rd_valid_o,
  output fltpw_pkg::step_t rd_data_o
);
  import fltpw_pkg::*;

  step_t            mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QCntW-1:0] count_q;

  assign full_o     = count_q == QCntW'(QDepth);
  assign rd_valid_o = count_q != '0;
  assign rd_data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (wr_i) begin
        wptr_q <= (wptr_q == QPtrW'(QDepth - 1)) ? '0 : wptr_q + QPtrW'(1);
      end
      if (rd_i) begin
        rptr_q <= (rptr_q == QPtrW'(QDepth - 1)) ? '0 : rptr_q + QPtrW'(1);
      end
      count_q <= count_q + QCntW'(wr_i) - QCntW'(rd_i);
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QDepth))
    else $error("queue count overflow");

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> !full_o)
    else $error("write into full queue");

  a_no_read_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> rd_valid_o)
    else $error("read from empty queue");

endmodule

[hdl/fltpw_back.sv]
// Back end: forms addresses for each step and holds the result register.
module fltpw_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_valid_i,
  input  fltpw_pkg::step_t             rd_data_i,
  output logic                         rd_o,
  input  logic                         pop_i,
  output logic                         empty_o,
  output logic [1:0]                   out_kind_o,
  output logic [fltpw_pkg::AddrW-1:0]  entry_address_o,
  output logic [fltpw_pkg::AddrW-1:0]  frame_base_o,
  output logic [fltpw_pkg::LevelW-1:0] walk_level_o,
  output logic [fltpw_pkg::EntryW-1:0] captured_entry_o
);
  import fltpw_pkg::*;

  logic               valid_q;
  logic               load;
  kind_e              kind_q;
  logic [AddrW-1:0]   ea_q, ea_d;
  logic [AddrW-1:0]   fb_q, fb_d;
  logic [LevelW-1:0]  level_q;
  logic [EntryW-1:0]  entry_q;

  // refill the result register when it is free or being drained this cycle
  assign load    = rd_valid_i && (!valid_q || pop_i);
  assign rd_o    = load;
  assign empty_o = !valid_q;

  always_comb begin
    ea_d = '0;
    fb_d = '0;
    if (rd_data_i.kind == KindRead) begin
      ea_d = AddrW'({rd_data_i.frame, rd_data_i.idx, 3'b000});
    end
    if (rd_data_i.kind == KindDone) begin
      fb_d = AddrW'({rd_data_i.frame, {PageShift{1'b0}}});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= load || (valid_q && !pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= rd_data_i.kind;
      ea_q    <= ea_d;
      fb_q    <= fb_d;
      level_q <= rd_data_i.level;
      entry_q <= rd_data_i.entry;
    end
  end

  assign out_kind_o       = kind_q;
  assign entry_address_o  = ea_q;
  assign frame_base_o     = fb_q;
  assign walk_level_o     = level_q;
  assign captured_entry_o = entry_q;

  a_hold_until_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !pop_i |=> valid_q && $stable(entry_q) && $stable(ea_q))
    else $error("result dropped before transfer");

  a_addr_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && kind_q != KindRead |-> ea_q == '0)
    else $error("entry address set on non-read result");

  a_proto_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && kind_q == KindProto |-> entry_q == '0 && level_q == '0 && fb_q == '0)
    else $error("protocol error result carries data");

endmodule

[hdl/four_level_page_table_walker.sv]
// Top level: four-level page table walker, one walk step per transfer.
// A step passes through the step queue and then the result register before its result is visible.
// Throughput: one item per cycle while full is low; a two-entry step queue and one result register buffer it.
// Full rises only when the step queue holds two steps and the result is not drained.
// Reset (rst_ni low, asynchronous): walker idle at level 0, queue and result register empty.
module four_level_page_table_walker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic                            req_type_i,
  input  logic [fltpw_pkg::VaW-1:0]       virtual_address_i,
  input  logic [fltpw_pkg::FrameBits-1:0] root_frame_i,
  input  logic [fltpw_pkg::EntryW-1:0]    entry_data_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [1:0]                      out_kind_o,
  output logic [fltpw_pkg::AddrW-1:0]     entry_address_o,
  output logic [fltpw_pkg::AddrW-1:0]     frame_base_o,
  output logic [fltpw_pkg::LevelW-1:0]    walk_level_o,
  output logic [fltpw_pkg::EntryW-1:0]    captured_entry_o
);
  import fltpw_pkg::*;

  logic  q_wr, q_rd, q_valid;
  step_t q_wdata, q_rdata;

  fltpw_front u_front (
    .clk_i,
    .rst_ni,
    .push_i            (push),
    .full_i            (full),
    .req_type_i,
    .virtual_address_i,
    .root_frame_i,
    .entry_data_i,
    .wr_o              (q_wr),
    .wr_data_o         (q_wdata)
  );

  fltpw_queue u_queue (
    .clk_i,
    .rst_ni,
    .wr_i       (q_wr),
    .wr_data_i  (q_wdata),
    .full_o     (full),
    .rd_i       (q_rd),
    .rd_valid_o (q_valid),
    .rd_data_o  (q_rdata)
  );

  fltpw_back u_back (
    .clk_i,
    .rst_ni,
    .rd_valid_i (q_valid),
    .rd_data_i  (q_rdata),
    .rd_o       (q_rd),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_kind_o,
    .entry_address_o,
    .frame_base_o,
    .walk_level_o,
    .captured_entry_o
  );

endmodule
